@@ rtl/core/psd_pkg.sv @@
// Package for the point-to-segment squared distance unit.
// Widths, register codes and the pipeline stage record types; no dependencies.
`timescale 1ns / 1ps

package psd_pkg;

  localparam int COORD_WIDTH = 20;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SUM_W       = PROD_W + 1;
  // interior quotient and remainder stay below e < 2^PROD_W
  localparam int QW          = PROD_W;
  localparam int DIST_W      = 42;
  localparam int LIMIT_W     = 20;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [DIST_W-1:0]  DIST_MAX    = {DIST_W{1'b1}};
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

  typedef enum logic [0:0] {
    REG_DEGENERATE_LIMIT = 1'b0,
    REG_UNUSED           = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    REGION_DEGENERATE = 2'd0,
    REGION_START      = 2'd1,
    REGION_INTERIOR   = 2'd2,
    REGION_END        = 2'd3
  } region_t;

  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] e;
    logic signed [SUM_W-1:0] f;
    logic signed [SUM_W-1:0] ww;
    logic signed [SUM_W-1:0] uu;
  } front_t;

  typedef struct packed {
    logic             valid;
    region_t          region;
    logic [SUM_W-1:0] base;
    logic [QW-1:0]    f;
    logic [QW-1:0]    fsh;
    logic [QW-1:0]    e;
    logic [QW-1:0]    r;
    logic [QW-1:0]    qa;
    logic [QW-1:0]    qb;
  } div_t;

endpackage

@@ rtl/core/psd_front.sv @@
// Front end: coordinate differences, twelve products, and the four dot sums.
// Three register stages, all advancing on en. Depends on psd_pkg.
`timescale 1ns / 1ps

module psd_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] query_x,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] query_y,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] query_z,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] start_x,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] start_y,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] start_z,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] end_x,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] end_y,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] end_z,
  output psd_pkg::front_t                      result
);
  import psd_pkg::*;

  logic signed [DIFF_W-1:0] v [3];
  logic signed [DIFF_W-1:0] w [3];
  logic signed [DIFF_W-1:0] u [3];
  logic                     s1_valid;

  logic signed [PROD_W-1:0] pvv [3];
  logic signed [PROD_W-1:0] pvw [3];
  logic signed [PROD_W-1:0] pww [3];
  logic signed [PROD_W-1:0] puu [3];
  logic                     s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v[0] <= DIFF_W'(end_x) - DIFF_W'(start_x);
      v[1] <= DIFF_W'(end_y) - DIFF_W'(start_y);
      v[2] <= DIFF_W'(end_z) - DIFF_W'(start_z);
      w[0] <= DIFF_W'(query_x) - DIFF_W'(start_x);
      w[1] <= DIFF_W'(query_y) - DIFF_W'(start_y);
      w[2] <= DIFF_W'(query_z) - DIFF_W'(start_z);
      u[0] <= DIFF_W'(query_x) - DIFF_W'(end_x);
      u[1] <= DIFF_W'(query_y) - DIFF_W'(end_y);
      u[2] <= DIFF_W'(query_z) - DIFF_W'(end_z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pvv[k] <= v[k] * v[k];
        pvw[k] <= v[k] * w[k];
        pww[k] <= w[k] * w[k];
        puu[k] <= u[k] * u[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.e  <= SUM_W'(pvv[0]) + SUM_W'(pvv[1]) + SUM_W'(pvv[2]);
      result.f  <= SUM_W'(pvw[0]) + SUM_W'(pvw[1]) + SUM_W'(pvw[2]);
      result.ww <= SUM_W'(pww[0]) + SUM_W'(pww[1]) + SUM_W'(pww[2]);
      result.uu <= SUM_W'(puu[0]) + SUM_W'(puu[1]) + SUM_W'(puu[2]);
    end
  end

endmodule

@@ rtl/core/psd_div_stage.sv @@
// One step of the floor(f*f/e) divider: consumes one bit of f, MSB first.
// Registered stage advancing on en. Depends on psd_pkg.
`timescale 1ns / 1ps

module psd_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  psd_pkg::div_t d_in,
  output psd_pkg::div_t d_out
);
  import psd_pkg::*;

  logic [QW:0] e_x;
  logic [QW:0] r2;
  logic [QW:0] r1;
  logic [QW:0] r3;
  logic [QW:0] rn;
  logic        c1;
  logic        c2;
  div_t        d_next;

  always_comb begin
    e_x = {1'b0, d_in.e};
    r2  = {d_in.r, 1'b0};
    c1  = (r2 >= e_x);
    r1  = c1 ? (r2 - e_x) : r2;
    r3  = r1 + {1'b0, d_in.f};
    c2  = d_in.fsh[QW-1] && (r3 >= e_x);
    if (d_in.fsh[QW-1]) begin
      rn = c2 ? (r3 - e_x) : r3;
    end else begin
      rn = r1;
    end
    d_next       = d_in;
    d_next.r     = rn[QW-1:0];
    d_next.fsh   = {d_in.fsh[QW-2:0], 1'b0};
    d_next.qa    = {d_in.qa[QW-2:0], c1};
    d_next.qb    = {d_in.qb[QW-2:0], c2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out.valid <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.region <= d_next.region;
      d_out.base   <= d_next.base;
      d_out.f      <= d_next.f;
      d_out.fsh    <= d_next.fsh;
      d_out.e      <= d_next.e;
      d_out.r      <= d_next.r;
      d_out.qa     <= d_next.qa;
      d_out.qb     <= d_next.qb;
    end
  end

endmodule

@@ rtl/core/point_segment_squared_distance_unit.sv @@
// Point-to-segment squared distance, fully pipelined.
// Stages: 3 front, 1 classify, 42 divider steps (one per bit of f), 1 quotient
// sum, 1 output register. Throughput one transaction a cycle when not stalled.
// A stall on the output freezes the whole pipeline; in_stall follows it.
// Synchronous reset clears all valid bits and sets degenerate_limit to 1.
`timescale 1ns / 1ps

module point_segment_squared_distance_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [psd_pkg::ADDR_W-1:0]             paddr,
  input  logic [psd_pkg::DATA_W-1:0]             pwdata,
  output logic [psd_pkg::DATA_W-1:0]             prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] query_x,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] query_y,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] query_z,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] start_x,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] start_y,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] start_z,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] end_x,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] end_y,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] end_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [psd_pkg::DIST_W-1:0]             dist_sq,
  output logic [1:0]                             region
);
  import psd_pkg::*;

  logic               en;
  logic [LIMIT_W-1:0] degenerate_limit;
  reg_index_t         reg_idx;
  front_t             front;
  div_t               div_head;
  div_t               chain [QW+1];
  div_t               cls_next;
  logic               e_lt_lim;
  logic               f_pos;
  logic               f_ge_e;

  logic               qs_valid;
  region_t            qs_region;
  logic [SUM_W-1:0]   qs_base;
  logic [QW:0]        qs_q;
  logic [SUM_W:0]     dist_full;
  logic [SUM_W:0]     base_x;
  logic [SUM_W:0]     q_x;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // config port
  assign pready  = 1'b1;
  assign reg_idx = reg_index_t'(paddr[ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      degenerate_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_idx == REG_DEGENERATE_LIMIT) begin
      degenerate_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEGENERATE_LIMIT: prdata = DATA_W'(degenerate_limit);
      default:              prdata = '0;
    endcase
  end

  psd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_valid(in_valid),
    .query_x (query_x),
    .query_y (query_y),
    .query_z (query_z),
    .start_x (start_x),
    .start_y (start_y),
    .start_z (start_z),
    .end_x   (end_x),
    .end_y   (end_y),
    .end_z   (end_z),
    .result  (front)
  );

  // classify; the divider only sees real operands in the interior case
  always_comb begin
    e_lt_lim = $unsigned(front.e) < SUM_W'(degenerate_limit);
    f_pos    = !front.f[SUM_W-1] && (front.f != '0);
    f_ge_e   = front.f >= front.e;
    cls_next       = '0;
    cls_next.valid = front.valid;
    cls_next.base  = $unsigned(front.ww);
    cls_next.e     = QW'(1);
    if (e_lt_lim) begin
      cls_next.region = REGION_DEGENERATE;
    end else if (!f_pos) begin
      cls_next.region = REGION_START;
    end else if (f_ge_e) begin
      cls_next.region = REGION_END;
      cls_next.base   = $unsigned(front.uu);
    end else begin
      cls_next.region = REGION_INTERIOR;
      cls_next.f      = front.f[QW-1:0];
      cls_next.fsh    = front.f[QW-1:0];
      cls_next.e      = front.e[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_head.valid <= 1'b0;
    end else if (en) begin
      div_head.valid <= cls_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_head.region <= cls_next.region;
      div_head.base   <= cls_next.base;
      div_head.f      <= cls_next.f;
      div_head.fsh    <= cls_next.fsh;
      div_head.e      <= cls_next.e;
      div_head.r      <= cls_next.r;
      div_head.qa     <= cls_next.qa;
      div_head.qb     <= cls_next.qb;
    end
  end

  assign chain[0] = div_head;

  for (genvar g = 0; g < QW; g++) begin : g_div
    psd_div_stage u_stage (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .d_in (chain[g]),
      .d_out(chain[g+1])
    );
  end

  // quotient bits were collected in two vectors; merge them
  always_ff @(posedge clk) begin
    if (rst) begin
      qs_valid <= 1'b0;
    end else if (en) begin
      qs_valid <= chain[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qs_region <= chain[QW].region;
      qs_base   <= chain[QW].base;
      qs_q      <= {1'b0, chain[QW].qa} + {1'b0, chain[QW].qb};
    end
  end

  always_comb begin
    base_x = {1'b0, qs_base};
    q_x    = (SUM_W+1)'(qs_q);
    if (qs_region == REGION_INTERIOR) begin
      dist_full = (base_x >= q_x) ? (base_x - q_x) : '0;
    end else begin
      dist_full = base_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= qs_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      region  <= qs_region;
      dist_sq <= (dist_full > (SUM_W+1)'(DIST_MAX)) ? DIST_MAX : dist_full[DIST_W-1:0];
    end
  end

endmodule
